[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the oriented box overlap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle, checked outside reset.
`define OBB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next, checked outside reset.
`define OBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/obb_pkg.sv]
// Package with the constants and the arctangent table of the oriented box overlap block.
`timescale 1ns / 1ps
package obb_pkg;

	// Angle input width and trigonometric result format (signed Q1.14 plus guard).
	localparam int ANGLE_W = 16;
	localparam int TRIG_W = 18;
	localparam int TRIG_FRAC = 14;

	// CORDIC datapath: x and y in Q2.30, z in units of 2^-32 turn.
	localparam int CD_W = 34;
	localparam int TABLE_LEN = 24;
	localparam logic signed [CD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [CD_W-1:0] atan_turn(input int idx);
		logic signed [CD_W-1:0] r;
		case (idx)
			0: r = 34'sh020000000;
			1: r = 34'sh012E4051E;
			2: r = 34'sh009FB385B;
			3: r = 34'sh0051111D4;
			4: r = 34'sh0028B0D43;
			5: r = 34'sh00145D7E1;
			6: r = 34'sh000A2F61E;
			7: r = 34'sh000517C55;
			8: r = 34'sh00028BE53;
			9: r = 34'sh000145F2F;
			10: r = 34'sh0000A2F98;
			11: r = 34'sh0000517CC;
			12: r = 34'sh000028BE6;
			13: r = 34'sh0000145F3;
			14: r = 34'sh00000A2FA;
			15: r = 34'sh00000517D;
			16: r = 34'sh0000028BE;
			17: r = 34'sh00000145F;
			18: r = 34'sh000000A30;
			19: r = 34'sh000000518;
			20: r = 34'sh00000028C;
			21: r = 34'sh000000146;
			22: r = 34'sh0000000A3;
			23: r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/obb_in_if.sv]
// Input channel carrying one pair of oriented boxes per item.
`timescale 1ns / 1ps
interface obb_in_if #(
	parameter int CW = 16
);
	logic valid;
	logic ready;
	logic signed [CW-1:0] a_center_x;
	logic signed [CW-1:0] a_center_y;
	logic [CW-2:0] a_width;
	logic [CW-2:0] a_height;
	logic [15:0] a_angle;
	logic signed [CW-1:0] b_center_x;
	logic signed [CW-1:0] b_center_y;
	logic [CW-2:0] b_width;
	logic [CW-2:0] b_height;
	logic [15:0] b_angle;

	modport source (output valid, a_center_x, a_center_y, a_width, a_height, a_angle,
		b_center_x, b_center_y, b_width, b_height, b_angle, input ready);
	modport sink (input valid, a_center_x, a_center_y, a_width, a_height, a_angle,
		b_center_x, b_center_y, b_width, b_height, b_angle, output ready);
endinterface

[hdl/obb_out_if.sv]
// Output channel carrying one overlap decision per item.
`timescale 1ns / 1ps
interface obb_out_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

[hdl/obb_cordic.sv]
// Pipelined rotation-mode CORDIC giving cosine and sine of a turn fraction.
`timescale 1ns / 1ps
module obb_cordic import obb_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic [ANGLE_W-1:0] angle,
	output logic signed [TRIG_W-1:0] cos_v,
	output logic signed [TRIG_W-1:0] sin_v
);

	logic signed [CD_W-1:0] x_s [STEPS+1];
	logic signed [CD_W-1:0] y_s [STEPS+1];
	logic signed [CD_W-1:0] z_s [STEPS+1];
	logic flip_s [STEPS+1];
	logic flip;
	logic signed [CD_W-1:0] x_neg, y_neg, x_rnd, y_rnd;

	// Fold the angle into a quarter turn either side of zero; a half turn negates both results.
	assign flip = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= CD_W'($signed({angle[ANGLE_W-1] ^ flip, angle[ANGLE_W-2:0], 16'b0}));
			flip_s[0] <= flip;
		end
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CD_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turn(i);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	// Undo the fold and round Q2.30 to Q1.14.
	always_comb begin
		x_neg = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		y_neg = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
		x_rnd = x_neg + CD_W'(34'sd1 <<< (29 - TRIG_FRAC));
		y_rnd = y_neg + CD_W'(34'sd1 <<< (29 - TRIG_FRAC));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= x_rnd[CD_W-1:CD_W-TRIG_W];
			sin_v <= y_rnd[CD_W-1:CD_W-TRIG_W];
		end
	end

endmodule

[hdl/obb_box.sv]
// One box: cosine and sine of its angle, then its four corners in widened fixed point.
`timescale 1ns / 1ps
module obb_box import obb_pkg::*; #(
	parameter int CW = 16,
	parameter int STEPS = 16,
	localparam int CRW = CW + 18,
	localparam int DLY = STEPS + 2
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] center_x,
	input  logic signed [CW-1:0] center_y,
	input  logic [CW-2:0] width,
	input  logic [CW-2:0] height,
	input  logic [ANGLE_W-1:0] angle,
	output logic signed [CRW-1:0] vx [4],
	output logic signed [CRW-1:0] vy [4],
	output logic signed [TRIG_W-1:0] cos_v,
	output logic signed [TRIG_W-1:0] sin_v,
	output logic w_nz,
	output logic h_nz
);

	logic signed [TRIG_W-1:0] c_cd, s_cd;
	logic signed [CW-1:0] cx_d [DLY];
	logic signed [CW-1:0] cy_d [DLY];
	logic [CW-2:0] w_d [DLY];
	logic [CW-2:0] h_d [DLY];
	logic signed [CRW-1:0] wc_s1, ws_s1, hc_s1, hs_s1, px_s1, py_s1;
	logic signed [TRIG_W-1:0] c_s1, s_s1;
	logic wnz_s1, hnz_s1;

	obb_cordic #(.STEPS(STEPS)) u_cordic (
		.clk(clk), .en(en), .angle(angle), .cos_v(c_cd), .sin_v(s_cd)
	);

	// Hold the geometry alongside the CORDIC pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			cx_d[0] <= center_x;
			cy_d[0] <= center_y;
			w_d[0] <= width;
			h_d[0] <= height;
			for (int k = 1; k < DLY; k++) begin
				cx_d[k] <= cx_d[k-1];
				cy_d[k] <= cy_d[k-1];
				w_d[k] <= w_d[k-1];
				h_d[k] <= h_d[k-1];
			end
		end
	end

	// Half sizes times the rotation, and the center scaled to the same units.
	always_ff @(posedge clk) begin
		if (en) begin
			wc_s1 <= CRW'($signed({1'b0, w_d[DLY-1]})) * CRW'(c_cd);
			ws_s1 <= CRW'($signed({1'b0, w_d[DLY-1]})) * CRW'(s_cd);
			hc_s1 <= CRW'($signed({1'b0, h_d[DLY-1]})) * CRW'(c_cd);
			hs_s1 <= CRW'($signed({1'b0, h_d[DLY-1]})) * CRW'(s_cd);
			px_s1 <= CRW'(cx_d[DLY-1]) <<< (TRIG_FRAC + 1);
			py_s1 <= CRW'(cy_d[DLY-1]) <<< (TRIG_FRAC + 1);
			c_s1 <= c_cd;
			s_s1 <= s_cd;
			wnz_s1 <= (w_d[DLY-1] != '0);
			hnz_s1 <= (h_d[DLY-1] != '0);
		end
	end

	// Corners, counterclockwise from the front left.
	always_ff @(posedge clk) begin
		if (en) begin
			vx[0] <= px_s1 + wc_s1 - hs_s1;
			vy[0] <= py_s1 + ws_s1 + hc_s1;
			vx[1] <= px_s1 - wc_s1 - hs_s1;
			vy[1] <= py_s1 - ws_s1 + hc_s1;
			vx[2] <= px_s1 - wc_s1 + hs_s1;
			vy[2] <= py_s1 - ws_s1 - hc_s1;
			vx[3] <= px_s1 + wc_s1 + hs_s1;
			vy[3] <= py_s1 + ws_s1 - hc_s1;
			cos_v <= c_s1;
			sin_v <= s_s1;
			w_nz <= wnz_s1;
			h_nz <= hnz_s1;
		end
	end

endmodule

[hdl/obb_lane.sv]
// One axis lane: projects both boxes onto an axis and checks the intervals overlap.
`timescale 1ns / 1ps
module obb_lane import obb_pkg::*; #(
	parameter int CW = 16,
	localparam int CRW = CW + 18,
	localparam int PW = CW + 37
) (
	input  logic clk,
	input  logic en,
	input  logic signed [TRIG_W-1:0] ax,
	input  logic signed [TRIG_W-1:0] ay,
	input  logic skip,
	input  logic signed [CRW-1:0] a_x [4],
	input  logic signed [CRW-1:0] a_y [4],
	input  logic signed [CRW-1:0] b_x [4],
	input  logic signed [CRW-1:0] b_y [4],
	output logic ok
);

	logic signed [PW-1:0] pa_s1 [4];
	logic signed [PW-1:0] pb_s1 [4];
	logic skip_s1, skip_s2;
	logic signed [PW-1:0] lo_a, hi_a, lo_b, hi_b;
	logic signed [PW-1:0] lo_a_s2, hi_a_s2, lo_b_s2, hi_b_s2;

	// Dot products of every corner with the axis.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pa_s1[k] <= PW'(a_x[k]) * PW'(ax) + PW'(a_y[k]) * PW'(ay);
				pb_s1[k] <= PW'(b_x[k]) * PW'(ax) + PW'(b_y[k]) * PW'(ay);
			end
			skip_s1 <= skip;
		end
	end

	// Interval of each box along the axis.
	always_comb begin
		lo_a = pa_s1[0];
		hi_a = pa_s1[0];
		lo_b = pb_s1[0];
		hi_b = pb_s1[0];
		for (int k = 1; k < 4; k++) begin
			if (pa_s1[k] < lo_a) lo_a = pa_s1[k];
			if (pa_s1[k] > hi_a) hi_a = pa_s1[k];
			if (pb_s1[k] < lo_b) lo_b = pb_s1[k];
			if (pb_s1[k] > hi_b) hi_b = pb_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_a_s2 <= lo_a;
			hi_a_s2 <= hi_a;
			lo_b_s2 <= lo_b;
			hi_b_s2 <= hi_b;
			skip_s2 <= skip_s1;
		end
	end

	// Touching intervals count as overlapping; a zero-length edge never separates.
	always_ff @(posedge clk) begin
		if (en) begin
			ok <= skip_s2 || !(hi_a_s2 < lo_b_s2 || hi_b_s2 < lo_a_s2);
		end
	end

endmodule

[hdl/oriented_box_overlap_test.sv]
// Top level of the oriented box overlap test: two boxes, four axis lanes, merged verdict.
`timescale 1ns / 1ps
// Tests two rotated rectangles for overlap by the separating axis theorem and returns one
// bit per item, 1 when they overlap or touch. The block takes one item every clock cycle
// while the output is not stalled; each accepted item passes through the CORDIC of each
// box, one stage per iteration, followed by the corner, projection, interval, comparison
// and merge stages. The whole pipeline advances together: while a result waits at the
// output and is not taken, no stage moves and no new item is accepted.
`include "assert_macros.svh"
module oriented_box_overlap_test import obb_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	obb_in_if.sink boxes,
	obb_out_if.source result
);

	localparam int CRW = COORD_WIDTH + 18;
	localparam int LAT = CORDIC_STEPS + 8;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic overlap_q;
	logic signed [CRW-1:0] a_vx [4];
	logic signed [CRW-1:0] a_vy [4];
	logic signed [CRW-1:0] b_vx [4];
	logic signed [CRW-1:0] b_vy [4];
	logic signed [TRIG_W-1:0] ca, sa, cb, sb, nsa, nsb;
	logic a_wnz, a_hnz, b_wnz, b_hnz;
	logic [3:0] lane_ok;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv = !result.valid || result.ready;
	assign boxes.ready = adv;

	obb_box #(.CW(COORD_WIDTH), .STEPS(CORDIC_STEPS)) u_box_a (
		.clk(clk), .en(adv),
		.center_x(boxes.a_center_x), .center_y(boxes.a_center_y),
		.width(boxes.a_width), .height(boxes.a_height), .angle(boxes.a_angle),
		.vx(a_vx), .vy(a_vy), .cos_v(ca), .sin_v(sa), .w_nz(a_wnz), .h_nz(a_hnz)
	);

	obb_box #(.CW(COORD_WIDTH), .STEPS(CORDIC_STEPS)) u_box_b (
		.clk(clk), .en(adv),
		.center_x(boxes.b_center_x), .center_y(boxes.b_center_y),
		.width(boxes.b_width), .height(boxes.b_height), .angle(boxes.b_angle),
		.vx(b_vx), .vy(b_vy), .cos_v(cb), .sin_v(sb), .w_nz(b_wnz), .h_nz(b_hnz)
	);

	assign nsa = -sa;
	assign nsb = -sb;

	// Edge normals of both boxes, one lane each.
	obb_lane #(.CW(COORD_WIDTH)) u_lane_aw (
		.clk(clk), .en(adv), .ax(nsa), .ay(ca), .skip(!a_wnz),
		.a_x(a_vx), .a_y(a_vy), .b_x(b_vx), .b_y(b_vy), .ok(lane_ok[0])
	);

	obb_lane #(.CW(COORD_WIDTH)) u_lane_ah (
		.clk(clk), .en(adv), .ax(ca), .ay(sa), .skip(!a_hnz),
		.a_x(a_vx), .a_y(a_vy), .b_x(b_vx), .b_y(b_vy), .ok(lane_ok[1])
	);

	obb_lane #(.CW(COORD_WIDTH)) u_lane_bw (
		.clk(clk), .en(adv), .ax(nsb), .ay(cb), .skip(!b_wnz),
		.a_x(a_vx), .a_y(a_vy), .b_x(b_vx), .b_y(b_vy), .ok(lane_ok[2])
	);

	obb_lane #(.CW(COORD_WIDTH)) u_lane_bh (
		.clk(clk), .en(adv), .ax(cb), .ay(sb), .skip(!b_hnz),
		.a_x(a_vx), .a_y(a_vy), .b_x(b_vx), .b_y(b_vy), .ok(lane_ok[3])
	);

	// Merge: the boxes overlap when no lane found a separating axis.
	always_ff @(posedge clk) begin
		if (adv) begin
			overlap_q <= &lane_ok;
		end
	end

	// Item valid flags travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], boxes.valid};
		end
	end

	assign result.valid = vld_q[LAT-1];
	assign result.overlap = overlap_q;

	// A stalled pipeline keeps every item in place.
	`OBB_ASSERT_NEXT(a_stall_holds, clk, arst_n, !adv, $stable(vld_q), "pipeline moved while stalled")
	// A waiting result blocks new items.
	`OBB_ASSERT(a_block_input, clk, arst_n, !(result.valid && !result.ready && boxes.ready), "item accepted behind a waiting result")
	// An output that is taken frees the input in the same cycle.
	`OBB_ASSERT(a_free_input, clk, arst_n, !(result.ready && !boxes.ready), "input blocked although result is taken")

endmodule

[bench/oriented_box_overlap_test_test.sv]
// Self-checking testbench for the oriented box overlap block.
`timescale 1ns / 1ps
module oriented_box_overlap_test_test;

	localparam int CW = 16;
	localparam int STEPS = 16;
	localparam int RANDOM_PAIRS = 500;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_OFF = 300;

	typedef struct {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [CW-2:0] w;
		logic [CW-2:0] h;
		logic [15:0] ang;
	} box_t;

	typedef struct {
		box_t a;
		box_t b;
		int verdict_hint;
	} pair_row_t;

	logic clk;
	logic arst_n;
	obb_in_if #(.CW(CW)) boxes_if ();
	obb_out_if result_if ();

	oriented_box_overlap_test #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.boxes(boxes_if),
		.result(result_if)
	);

	// Arctangent of 2^-i in units of 2^-32 turn.
	longint arctan_turn [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	pair_row_t pairs_table [$];
	int verdict_hints [$];
	bit verdicts_due [$];
	int failures = 0;
	int idle_cycles = 0;
	int pairs_sent = 0;

	// Cosine and sine of a turn fraction, rounded to Q1.14.
	function automatic void rotation_trig(input logic [15:0] ang, output longint c,
		output longint s);
		logic [31:0] th;
		bit flip;
		longint x, y, z, nx;
		th = {ang, 16'h0000};
		flip = th[31] ^ th[30];
		if (flip) begin
			th = th - 32'h80000000;
		end
		z = longint'(signed'(th));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - arctan_turn[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + arctan_turn[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + (64'sd1 << 15)) >>> 16;
		s = (y + (64'sd1 << 15)) >>> 16;
	endfunction

	// Separating axis decision for one pair: 1 when no axis separates the boxes.
	function automatic bit boxes_intersect(input box_t a, input box_t b);
		box_t bx [2];
		longint vx [2][4];
		longint vy [2][4];
		longint c [2], s [2], w [2], h [2];
		longint px, py, wc, ws, hc, hs, ax, ay, p, lo [2], hi [2];
		bit hit;
		bx[0] = a;
		bx[1] = b;
		for (int k = 0; k < 2; k++) begin
			px = longint'(bx[k].cx) * 32768;
			py = longint'(bx[k].cy) * 32768;
			w[k] = longint'(bx[k].w);
			h[k] = longint'(bx[k].h);
			rotation_trig(bx[k].ang, c[k], s[k]);
			wc = w[k] * c[k]; ws = w[k] * s[k];
			hc = h[k] * c[k]; hs = h[k] * s[k];
			vx[k][0] = px + wc - hs; vy[k][0] = py + ws + hc;
			vx[k][1] = px - wc - hs; vy[k][1] = py - ws + hc;
			vx[k][2] = px - wc + hs; vy[k][2] = py - ws - hc;
			vx[k][3] = px + wc + hs; vy[k][3] = py + ws - hc;
		end
		hit = 1;
		// Two normals per box; an axis of zero-length edge never separates.
		for (int k = 0; k < 2; k++) begin
			for (int n = 0; n < 2; n++) begin
				if ((n == 0 && w[k] != 0) || (n == 1 && h[k] != 0)) begin
					ax = (n == 0) ? -s[k] : c[k];
					ay = (n == 0) ? c[k] : s[k];
					for (int q = 0; q < 2; q++) begin
						for (int v = 0; v < 4; v++) begin
							p = vx[q][v] * ax + vy[q][v] * ay;
							if (v == 0 || p < lo[q]) lo[q] = p;
							if (v == 0 || p > hi[q]) hi[q] = p;
						end
					end
					if (hi[0] < lo[1] || hi[1] < lo[0]) begin
						hit = 0;
					end
				end
			end
		end
		return hit;
	endfunction

	function automatic box_t make_box(input int cx, input int cy, input int w, input int h,
		input int ang);
		box_t r;
		r.cx = CW'(cx);
		r.cy = CW'(cy);
		r.w = (CW-1)'(w);
		r.h = (CW-1)'(h);
		r.ang = 16'(ang);
		return r;
	endfunction

	function automatic box_t random_box();
		return make_box($urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Reset, once at the start.
	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// Checker: expectations are formed on input acceptance, compared on output acceptance.
	always @(posedge clk) begin
		bit want;
		box_t a, b;
		int hint;
		if (arst_n) begin
			if ((boxes_if.valid && boxes_if.ready) || (result_if.valid && result_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (boxes_if.valid && boxes_if.ready) begin
				a = make_box(int'(boxes_if.a_center_x), int'(boxes_if.a_center_y),
					int'(boxes_if.a_width), int'(boxes_if.a_height), int'(boxes_if.a_angle));
				b = make_box(int'(boxes_if.b_center_x), int'(boxes_if.b_center_y),
					int'(boxes_if.b_width), int'(boxes_if.b_height), int'(boxes_if.b_angle));
				hint = verdict_hints.pop_front();
				want = (hint >= 0) ? hint[0] : boxes_intersect(a, b);
				verdicts_due.push_back(want);
			end
			if (result_if.valid && result_if.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected item, overlap %b", $realtime, result_if.overlap);
					failures++;
				end else begin
					want = verdicts_due.pop_front();
					if (result_if.overlap !== want) begin
						$display("%0t: overlap mismatch, expected %b, actual %b", $realtime,
							want, result_if.overlap);
						failures++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no progress.
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("** oriented_box_overlap_test: FAILED **");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps offering.
	initial begin
		bit held = 0;
		result_if.ready = 0;
		@(posedge clk);
		wait (arst_n);
		forever begin
			if (!held && pairs_sent >= 100) begin
				held = 1;
				result_if.ready <= 0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			result_if.ready <= 1;
			repeat (($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 15)) @(posedge clk);
			if ($urandom_range(0, 2) != 0) begin
				result_if.ready <= 0;
				repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 3)) @(posedge clk);
			end
		end
	end

	// Offer one pair and hold it until accepted, then maybe idle.
	task automatic send_pair(input box_t a, input box_t b, input int hint);
		int gap;
		verdict_hints.push_back(hint);
		boxes_if.valid <= 1;
		boxes_if.a_center_x <= a.cx;
		boxes_if.a_center_y <= a.cy;
		boxes_if.a_width <= a.w;
		boxes_if.a_height <= a.h;
		boxes_if.a_angle <= a.ang;
		boxes_if.b_center_x <= b.cx;
		boxes_if.b_center_y <= b.cy;
		boxes_if.b_width <= b.w;
		boxes_if.b_height <= b.h;
		boxes_if.b_angle <= b.ang;
		do @(posedge clk); while (!boxes_if.ready);
		pairs_sent++;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2);
		if (pairs_sent > 60 && pairs_sent < 160) gap = 0;
		if ($urandom_range(0, 24) == 0) gap = $urandom_range(20, 60);
		if (gap > 0) begin
			boxes_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender: directed rows, then random pairs, then the drain and verdict.
	initial begin
		box_t a, b;
		int dx, dy;
		boxes_if.valid = 0;
		boxes_if.a_center_x = '0;
		boxes_if.a_center_y = '0;
		boxes_if.a_width = '0;
		boxes_if.a_height = '0;
		boxes_if.a_angle = '0;
		boxes_if.b_center_x = '0;
		boxes_if.b_center_y = '0;
		boxes_if.b_width = '0;
		boxes_if.b_height = '0;
		boxes_if.b_angle = '0;

		// Directed rows; a hint of -1 leaves the verdict to the predictor.
		pairs_table = '{
			'{make_box(0, 0, 160, 160, 0), make_box(0, 0, 160, 160, 0), 1},
			'{make_box(0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0), 1},
			'{make_box(-32768, -32768, 16, 16, 0), make_box(32767, 32767, 16, 16, 0), 0},
			'{make_box(32767, -32768, 16, 16, 16'h8000), make_box(-32768, 32767, 16, 16, 0), 0},
			'{make_box(0, 0, 32767, 32767, 16'hFFFF), make_box(0, 0, 32767, 32767, 16'h4000), 1},
			'{make_box(-32768, 0, 32767, 32767, 0), make_box(32767, 0, 32767, 32767, 0), -1},
			'{make_box(0, 0, 320, 160, 0), make_box(320, 0, 320, 160, 0), -1},
			'{make_box(0, 0, 320, 160, 0), make_box(321, 0, 320, 160, 0), -1},
			'{make_box(0, 0, 320, 160, 16'h2000), make_box(300, 0, 320, 160, 0), -1},
			'{make_box(0, 0, 320, 160, 16'h4000), make_box(0, 250, 320, 160, 16'hC000), -1},
			'{make_box(0, 0, 320, 0, 16'h1000), make_box(100, 50, 0, 320, 16'h3000), -1},
			'{make_box(0, 0, 0, 320, 16'h8000), make_box(0, 100, 320, 0, 16'hA000), -1},
			'{make_box(100, 100, 400, 40, 16'h2000), make_box(-100, -100, 400, 40, 16'hE000), -1},
			'{make_box(0, 0, 400, 40, 16'h6000), make_box(260, 260, 400, 40, 16'h2000), -1},
			'{make_box(32767, 32767, 0, 0, 16'hFFFF), make_box(32767, 32767, 0, 0, 0), 1}
		};
		wait (arst_n);
		@(posedge clk);
		foreach (pairs_table[i]) begin
			send_pair(pairs_table[i].a, pairs_table[i].b, pairs_table[i].verdict_hint);
		end

		// Random pairs: mostly near each other so both verdicts occur, some full range.
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			a = random_box();
			b = random_box();
			if ($urandom_range(0, 4) != 0) begin
				a.w = (CW-1)'($urandom_range(0, 2000));
				a.h = (CW-1)'($urandom_range(0, 2000));
				b.w = (CW-1)'($urandom_range(0, 2000));
				b.h = (CW-1)'($urandom_range(0, 2000));
				dx = int'($urandom_range(0, 3000)) - 1500;
				dy = int'($urandom_range(0, 3000)) - 1500;
				a.cx = CW'(int'($urandom_range(0, 40000)) - 20000);
				a.cy = CW'(int'($urandom_range(0, 40000)) - 20000);
				b.cx = CW'(int'(a.cx) + dx);
				b.cy = CW'(int'(a.cy) + dy);
			end
			send_pair(a, b, -1);
		end
		boxes_if.valid <= 0;

		wait (verdicts_due.size() == 0 && verdict_hints.size() == 0);
		repeat (STEPS + 40) @(posedge clk);
		if (failures == 0 && verdicts_due.size() == 0) begin
			$display("** oriented_box_overlap_test: PASSED **");
		end else begin
			$display("** oriented_box_overlap_test: FAILED **");
		end
		$finish;
	end

endmodule
